>>> rtl/gradient_noise_3d_eval_assert.svh
// Assertion macros shared by the noise evaluator.
`ifndef GRADIENT_NOISE_3D_EVAL_ASSERT_SVH
`define GRADIENT_NOISE_3D_EVAL_ASSERT_SVH

// A condition that must hold whenever the block is out of reset.
`define GN_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// An implication whose consequent is checked in the next cycle.
`define GN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/gn3d_pkg.sv
package gn3d_pkg;

    localparam int unsigned FracBits = 16;
    localparam int unsigned OutW     = 18;
    localparam int unsigned FadeW    = FracBits + 1;
    localparam int unsigned DW       = FracBits + 2;

    typedef enum logic [1:0] {
        CFG_SCALE = 2'd0,
        CFG_MODE  = 2'd1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_RAW    = 2'd0,
        MODE_LINEAR = 2'd1,
        MODE_ABS    = 2'd2,
        MODE_SPARE  = 2'd3
    } t_mode;

    typedef logic signed [OutW-1:0] t_noise;

    localparam logic [3:0] PERM [16] = '{
        4'd12, 4'd7, 4'd15, 4'd6, 4'd11, 4'd0, 4'd4, 4'd9,
        4'd13, 4'd3, 4'd14, 4'd8, 4'd2, 4'd5, 4'd1, 4'd10
    };

    // Gradient components as 2-bit signed codes {x, y, z}.
    localparam logic [5:0] GRAD [16] = '{
        {2'sd1, 2'sd1, 2'sd0}, {-2'sd1, 2'sd1, 2'sd0},
        {2'sd1, -2'sd1, 2'sd0}, {-2'sd1, -2'sd1, 2'sd0},
        {2'sd1, 2'sd0, 2'sd1}, {-2'sd1, 2'sd0, 2'sd1},
        {2'sd1, 2'sd0, -2'sd1}, {-2'sd1, 2'sd0, -2'sd1},
        {2'sd0, 2'sd1, 2'sd1}, {2'sd0, -2'sd1, 2'sd1},
        {2'sd0, 2'sd1, -2'sd1}, {2'sd0, -2'sd1, -2'sd1},
        {2'sd1, 2'sd1, 2'sd0}, {-2'sd1, 2'sd1, 2'sd0},
        {2'sd0, -2'sd1, 2'sd1}, {2'sd0, -2'sd1, -2'sd1}
    };

    function automatic logic [3:0] hash3(input logic [3:0] cx, input logic [3:0] cy,
                                         input logic [3:0] cz);
        logic [3:0] a;
        logic [3:0] b;
        a = cy + PERM[cz];
        b = cx + PERM[a];
        return PERM[b];
    endfunction

    // Signed term g*d for a gradient code in {-1,0,1}.
    function automatic logic signed [DW+1:0] gmul(input logic [1:0] g,
                                                  input logic signed [DW-1:0] d);
        logic signed [DW+1:0] e;
        e = {{2{d[DW-1]}}, d};
        unique case (g)
            2'b01:   return e;
            2'b11:   return -e;
            default: return '0;
        endcase
    endfunction

endpackage

>>> rtl/gn3d_if.sv
interface gn3d_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    modport source (output valid, point_x, point_y, point_z, input ready);
    modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface gn3d_out_if;
    logic                 valid;
    logic                 ready;
    logic signed [17:0]   noise_value;
    modport source (output valid, noise_value, input ready);
    modport sink   (input valid, noise_value, output ready);
endinterface

interface gn3d_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/gn3d_fade.sv
// Quintic fade weight of one offset, four register stages, advancing on i_en.
module gn3d_fade (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [gn3d_pkg::DW-1:0]    i_d,
    output logic [gn3d_pkg::FadeW-1:0]        o_w
);
    localparam int unsigned F = gn3d_pkg::FracBits;
    localparam int unsigned TW = gn3d_pkg::FadeW;

    logic [TW-1:0]       r_t1;
    logic [TW-1:0]       r_t2a, r_t2sq;
    logic [TW-1:0]       r_t3;
    logic signed [F+6:0] r_q;
    logic [TW-1:0]       r_w;

    logic [TW-1:0]          n_abs;
    logic [2*TW-1:0]        n_sq;
    logic [2*TW-1:0]        n_cube;
    logic signed [F+6:0]    n_q;
    logic signed [TW+F+7:0] n_prod;
    logic signed [TW+F+7:0] n_w;

    always_comb begin
        n_abs  = i_d[gn3d_pkg::DW-1] ? TW'(-i_d) : TW'(i_d);
        n_sq   = r_t1 * r_t1;
        n_cube = r_t2sq * r_t2a;
        n_q    = (F+7)'(signed'(10 << F)) - (F+7)'(15 * r_t2a)
                 + (F+7)'(6 * r_t2sq);
        n_prod = signed'({1'b0, r_t3}) * r_q;
        n_w    = (TW+F+8)'(signed'(1 << F)) - (n_prod >>> F);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t1   <= n_abs;
            r_t2a  <= r_t1;
            r_t2sq <= TW'(n_sq >> F);
            r_t3   <= TW'(n_cube >> F);
            r_q    <= n_q;
            if (n_w < 0)
                r_w <= '0;
            else if (n_w > (TW+F+8)'(1 << F))
                r_w <= TW'(1 << F);
            else
                r_w <= TW'(n_w);
        end
    end

    assign o_w = r_w;
endmodule

>>> rtl/gradient_noise_3d_eval.sv
// Pipelined 3D gradient noise: one point per cycle unless the output stalls.
// Stages: scale multiply, cell/offset split with corner hashing, four fade
// stages, two weight-product stages, per-corner dot times weight, corner sum
// and conversion with saturation. A stall at the output freezes the whole
// pipeline; input ready is low only while the last stage holds an untaken
// result. scale and conversion_mode are written through the configuration
// channel, which is always ready.
`include "gradient_noise_3d_eval_assert.svh"

module gradient_noise_3d_eval (
    input  logic          i_clk,
    input  logic          i_rst_n,
    gn3d_in_if.sink       i_pt,
    gn3d_out_if.source    o_nz,
    gn3d_cfg_if.sink      i_cfg
);
    localparam int unsigned F  = gn3d_pkg::FracBits;
    localparam int unsigned DW = gn3d_pkg::DW;
    localparam int unsigned TW = gn3d_pkg::FadeW;
    localparam int unsigned NS = 11;

    logic [15:0]           r_scale;
    gn3d_pkg::t_mode       r_mode;
    logic [NS-1:0]         r_vld;
    logic                  w_en;

    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= 16'd256;
            r_mode  <= gn3d_pkg::MODE_RAW;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == gn3d_pkg::CFG_SCALE)
                r_scale <= i_cfg.data[15:0];
            else if (i_cfg.index == gn3d_pkg::CFG_MODE)
                r_mode <= gn3d_pkg::t_mode'(i_cfg.data[1:0]);
        end
    end

    assign w_en       = !r_vld[NS-1] || o_nz.ready;
    assign i_pt.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_vld <= '0;
        else if (w_en)
            r_vld <= {r_vld[NS-2:0], i_pt.valid};
    end

    // Stage 1: scaled positions.
    logic signed [48:0] r_pos [3];
    logic signed [48:0] n_prod [3];
    always_comb begin
        n_prod[0] = i_pt.point_x * signed'({1'b0, r_scale});
        n_prod[1] = i_pt.point_y * signed'({1'b0, r_scale});
        n_prod[2] = i_pt.point_z * signed'({1'b0, r_scale});
    end
    always_ff @(posedge i_clk) begin
        if (w_en)
            for (int a = 0; a < 3; a++)
                r_pos[a] <= n_prod[a] >>> 8;
    end

    // Stage 2: per corner offsets and gradient codes.
    logic signed [DW-1:0] r_d   [8][3];
    logic [5:0]           r_g   [8];
    logic [3:0]           n_cell [3];
    logic [F-1:0]         n_frac [3];
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_cell[a] = r_pos[a][F+3:F];
            n_frac[a] = r_pos[a][F-1:0];
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en)
            for (int c = 0; c < 8; c++) begin
                r_g[c] <= gn3d_pkg::GRAD[gn3d_pkg::hash3(n_cell[0] + 4'(c[2]),
                            n_cell[1] + 4'(c[1]), n_cell[2] + 4'(c[0]))];
                r_d[c][0] <= signed'({2'b00, n_frac[0]}) - (c[2] ? DW'(1 << F) : '0);
                r_d[c][1] <= signed'({2'b00, n_frac[1]}) - (c[1] ? DW'(1 << F) : '0);
                r_d[c][2] <= signed'({2'b00, n_frac[2]}) - (c[0] ? DW'(1 << F) : '0);
            end
    end

    // Stages 3-6: fade weights; dot products computed alongside and delayed.
    logic [TW-1:0]          w_w [8][3];
    logic signed [DW+1:0]   r_dot [4][8];
    for (genvar c = 0; c < 8; c++) begin : g_corner
        for (genvar a = 0; a < 3; a++) begin : g_axis
            gn3d_fade u_fade (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_d   (r_d[c][a]),
                .o_w   (w_w[c][a])
            );
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en)
            for (int c = 0; c < 8; c++) begin
                r_dot[0][c] <= gn3d_pkg::gmul(r_g[c][5:4], r_d[c][0])
                             + gn3d_pkg::gmul(r_g[c][3:2], r_d[c][1])
                             + gn3d_pkg::gmul(r_g[c][1:0], r_d[c][2]);
                for (int s = 1; s < 4; s++)
                    r_dot[s][c] <= r_dot[s-1][c];
            end
    end

    // Stages 7-8: weight product; stage 9: term.
    logic [TW-1:0]         r_wxy [8];
    logic [TW-1:0]         r_wz  [8];
    logic [TW-1:0]         r_wp  [8];
    logic signed [DW+1:0]  r_dot7 [8];
    logic signed [DW+1:0]  r_dot8 [8];
    logic signed [DW+1:0]  r_term [8];
    logic [2*TW-1:0]       n_m1 [8];
    logic [2*TW-1:0]       n_m2 [8];
    logic signed [DW+TW+2:0] n_m3 [8];
    always_comb begin
        for (int c = 0; c < 8; c++) begin
            n_m1[c] = w_w[c][0] * w_w[c][1];
            n_m2[c] = r_wxy[c] * r_wz[c];
            n_m3[c] = r_dot8[c] * signed'({1'b0, r_wp[c]});
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en)
            for (int c = 0; c < 8; c++) begin
                r_wxy[c]  <= TW'(n_m1[c] >> F);
                r_wz[c]   <= w_w[c][2];
                r_dot7[c] <= r_dot[3][c];
                r_wp[c]   <= TW'(n_m2[c] >> F);
                r_dot8[c] <= r_dot7[c];
                r_term[c] <= (DW+2)'(n_m3[c] >>> F);
            end
    end

    // Stage 10: corner sum; stage 11: conversion and saturation.
    logic signed [DW+5:0] r_sum;
    logic signed [DW+5:0] n_sum;
    logic signed [DW+6:0] n_cv;
    gn3d_pkg::t_noise     r_out;
    always_comb begin
        n_sum = '0;
        for (int c = 0; c < 8; c++)
            n_sum = n_sum + (DW+6)'(r_term[c]);
    end
    always_comb begin
        unique case (r_mode)
            gn3d_pkg::MODE_LINEAR: n_cv = (DW+7)'(r_sum + (DW+6)'(1 << F)) >>> 1;
            gn3d_pkg::MODE_ABS:    n_cv = (r_sum < 0) ? -(DW+7)'(r_sum) : (DW+7)'(r_sum);
            default:               n_cv = (DW+7)'(r_sum);
        endcase
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sum <= n_sum;
            if (n_cv > 131071)
                r_out <= 18'sh1FFFF;
            else if (n_cv < -131072)
                r_out <= 18'sh20000;
            else
                r_out <= gn3d_pkg::t_noise'(n_cv);
        end
    end

    assign o_nz.valid       = r_vld[NS-1];
    assign o_nz.noise_value = r_out;

    `GN_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, o_nz.valid && !o_nz.ready,
        o_nz.valid && $stable(o_nz.noise_value), "stalled result changed")
    `GN_ASSERT_ALWAYS(a_ready, i_clk, i_rst_n, i_pt.ready == (!o_nz.valid || o_nz.ready),
        "input ready does not follow the output stage")
    `GN_ASSERT_NEXT(a_advance, i_clk, i_rst_n, i_pt.valid && i_pt.ready, r_vld[0],
        "accepted point did not enter the pipeline")
endmodule

>>> sim/gradient_noise_3d_eval_test.sv
module gradient_noise_3d_eval_test;

    // Register indexes past the end of the list; writes to them must be ignored.
    localparam logic [1:0] CFG_UNUSED_A = 2'd2;
    localparam logic [1:0] CFG_UNUSED_B = 2'd3;
    localparam int         ONE          = 1 << 16;
    localparam int         CYCLE_LIMIT  = 400000;

    localparam int PERM_TBL [16] = '{12, 7, 15, 6, 11, 0, 4, 9, 13, 3, 14, 8, 2, 5, 1, 10};
    localparam int GRAD_TBL [16][3] = '{
        '{1, 1, 0}, '{-1, 1, 0}, '{1, -1, 0}, '{-1, -1, 0},
        '{1, 0, 1}, '{-1, 0, 1}, '{1, 0, -1}, '{-1, 0, -1},
        '{0, 1, 1}, '{0, -1, 1}, '{0, 1, -1}, '{0, -1, -1},
        '{1, 1, 0}, '{-1, 1, 0}, '{0, -1, 1}, '{0, -1, -1}
    };

    logic i_clk;
    logic i_rst_n;

    gn3d_in_if  pt_ch ();
    gn3d_out_if nz_ch ();
    gn3d_cfg_if cfg_ch ();

    gradient_noise_3d_eval dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (pt_ch),
        .o_nz    (nz_ch),
        .i_cfg   (cfg_ch)
    );

    logic [15:0]       cur_scale;
    gn3d_pkg::t_mode   cur_mode;
    gn3d_pkg::t_noise  noise_expected [$];
    int                error_count;
    int                cycle_count;
    bit                calm;

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    function automatic longint fade(input longint t);
        longint t2;
        longint t3;
        longint q;
        longint w;
        t2 = (t * t) >>> 16;
        t3 = (t2 * t) >>> 16;
        q  = 10 * ONE - 15 * t + 6 * t2;
        w  = ONE - ((t3 * q) >>> 16);
        if (w < 0) w = 0;
        if (w > ONE) w = ONE;
        return w;
    endfunction

    function automatic gn3d_pkg::t_noise noise_predict(input logic signed [31:0] px,
                                                       input logic signed [31:0] py,
                                                       input logic signed [31:0] pz);
        longint coord [3];
        int     lat_cell [3];
        longint frac [3];
        longint d [3];
        longint pos;
        longint dot;
        longint wp;
        longint acc;
        int     cx;
        int     cy;
        int     cz;
        int     h;
        coord[0] = px;
        coord[1] = py;
        coord[2] = pz;
        for (int a = 0; a < 3; a++) begin
            pos         = (coord[a] * longint'({1'b0, cur_scale})) >>> 8;
            lat_cell[a] = int'((pos >>> 16) & 15);
            frac[a]     = pos & (ONE - 1);
        end
        acc = 0;
        for (int c = 0; c < 8; c++) begin
            cx   = (lat_cell[0] + c[2]) & 15;
            cy   = (lat_cell[1] + c[1]) & 15;
            cz   = (lat_cell[2] + c[0]) & 15;
            h    = PERM_TBL[(cx + PERM_TBL[(cy + PERM_TBL[cz]) & 15]) & 15];
            d[0] = frac[0] - (c[2] ? ONE : 0);
            d[1] = frac[1] - (c[1] ? ONE : 0);
            d[2] = frac[2] - (c[0] ? ONE : 0);
            dot  = GRAD_TBL[h][0] * d[0] + GRAD_TBL[h][1] * d[1] + GRAD_TBL[h][2] * d[2];
            wp   = (fade(d[0] < 0 ? -d[0] : d[0]) * fade(d[1] < 0 ? -d[1] : d[1])) >>> 16;
            wp   = (wp * fade(d[2] < 0 ? -d[2] : d[2])) >>> 16;
            acc += (dot * wp) >>> 16;
        end
        if (cur_mode == gn3d_pkg::MODE_LINEAR) begin
            acc = (acc + ONE) >>> 1;
        end else if (cur_mode == gn3d_pkg::MODE_ABS) begin
            acc = acc < 0 ? -acc : acc;
        end
        if (acc > 131071) acc = 131071;
        if (acc < -131072) acc = -131072;
        return gn3d_pkg::t_noise'(acc);
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    // Input transfers produce expectations; output transfers are checked against them.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pt_ch.valid && pt_ch.ready) begin
                noise_expected.push_back(noise_predict(pt_ch.point_x, pt_ch.point_y,
                                                       pt_ch.point_z));
            end
            if (nz_ch.valid && nz_ch.ready) begin
                if (noise_expected.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %0d", nz_ch.noise_value));
                end else if (nz_ch.noise_value !== noise_expected[0]) begin
                    report_mismatch($sformatf("noise_value %0d, expected %0d",
                                              nz_ch.noise_value, noise_expected[0]));
                    void'(noise_expected.pop_front());
                end else begin
                    void'(noise_expected.pop_front());
                end
            end
        end
    end

    always @(negedge i_clk) begin
        nz_ch.ready <= calm || ($urandom_range(99) >= 15);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // All tasks below are entered and left at a falling edge.
    task automatic send_point(input logic signed [31:0] px, input logic signed [31:0] py,
                              input logic signed [31:0] pz);
        while (!calm && $urandom_range(99) < 15) begin
            pt_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        pt_ch.valid   <= 1'b1;
        pt_ch.point_x <= px;
        pt_ch.point_y <= py;
        pt_ch.point_z <= pz;
        @(posedge i_clk);
        while (!pt_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        pt_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (noise_expected.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        if (idx == gn3d_pkg::CFG_SCALE) cur_scale = value[15:0];
        else if (idx == gn3d_pkg::CFG_MODE) cur_mode = gn3d_pkg::t_mode'(value[1:0]);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] random_coord();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return $signed($urandom_range(16 * ONE)) - 8 * ONE;
            2:       return {16'($urandom_range(65535)),
                             16'($urandom_range(1) ? 0 : 16'hffff)};
            default: return {16'($signed($urandom_range(40)) - 20), 16'($urandom)};
        endcase
    endfunction

    task automatic test_directed();
        logic [31:0] edge_vals [8];
        edge_vals = '{32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
                      32'h0000_8000, 32'h0001_0000, 32'hffff_0000, 32'h5555_aaaa};
        for (int i = 0; i < 8; i++) begin
            send_point(edge_vals[i], edge_vals[(i + 3) % 8], edge_vals[(i + 5) % 8]);
        end
        send_point(32'haaaa_5555, 32'h0000_4000, 32'hffff_c000);
        wait_drained();
        write_reg(gn3d_pkg::CFG_MODE, gn3d_pkg::MODE_LINEAR);
        send_point(32'h0000_4000, 32'h0001_2000, 32'hfffe_8000);
        send_point(32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001);
        wait_drained();
        write_reg(gn3d_pkg::CFG_MODE, gn3d_pkg::MODE_ABS);
        write_reg(gn3d_pkg::CFG_SCALE, 32'h0000_ffff);
        send_point(32'h0000_4000, 32'h0001_2000, 32'hfffe_8000);
        send_point(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
        wait_drained();
        // The spare mode code passes the raw sum; unlisted indexes change nothing.
        write_reg(gn3d_pkg::CFG_MODE, gn3d_pkg::MODE_SPARE);
        write_reg(CFG_UNUSED_A, 32'hffff_ffff);
        write_reg(CFG_UNUSED_B, 32'h0000_0001);
        write_reg(gn3d_pkg::CFG_SCALE, 32'hffff_0000);
        send_point(32'h1234_5678, 32'h8765_4321, 32'h0f0f_f0f0);
        send_point(32'h0003_8000, 32'h0000_c000, 32'hfff0_4000);
        wait_drained();
    endtask

    task automatic test_random_phase(input logic [15:0] scale_val,
                                     input gn3d_pkg::t_mode mode_val,
                                     input int count, input bit quiet, input bit pause);
        write_reg(gn3d_pkg::CFG_SCALE, {16'($urandom), scale_val});
        write_reg(gn3d_pkg::CFG_MODE, {30'($urandom), mode_val});
        calm = quiet;
        for (int i = 0; i < count; i++) begin
            send_point(random_coord(), random_coord(), random_coord());
            if (pause && i == count / 2) wait_drained();
        end
        calm = 1'b0;
        wait_drained();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        calm          = 1'b0;
        error_count   = 0;
        cycle_count   = 0;
        cur_scale     = 16'd256;
        cur_mode      = gn3d_pkg::MODE_RAW;
        pt_ch.valid   = 1'b0;
        pt_ch.point_x = '0;
        pt_ch.point_y = '0;
        pt_ch.point_z = '0;
        nz_ch.ready   = 1'b0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = gn3d_pkg::CFG_SCALE;
        cfg_ch.data   = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random_phase(16'd256, gn3d_pkg::MODE_RAW, 150, 1'b0, 1'b1);
        test_random_phase(16'd0, gn3d_pkg::MODE_LINEAR, 100, 1'b1, 1'b0);
        test_random_phase(16'hffff, gn3d_pkg::MODE_ABS, 150, 1'b0, 1'b0);
        test_random_phase(16'($urandom), gn3d_pkg::MODE_SPARE, 100, 1'b0, 1'b0);
        test_random_phase(16'($urandom_range(1023)), gn3d_pkg::MODE_LINEAR, 150, 1'b0, 1'b0);
        test_random_phase(16'd1, gn3d_pkg::MODE_RAW, 100, 1'b0, 1'b0);

        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
